/* rtl/tvsg_pkg.sv */
`default_nettype none
package tvsg_pkg;
	localparam int RegCount = 16;
	localparam int DivW = 32;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ = 2'd1,
		OP_FRAME = 2'd2,
		OP_SAMPLE = 2'd3
	} op_t;

	localparam logic [3:0] REG_ENABLE = 4'd7;
	localparam logic [3:0] REG_VOL_A = 4'd8;
	localparam logic [3:0] REG_VOL_C = 4'd10;
	localparam logic [3:0] REG_ENV_FINE = 4'd11;
	localparam logic [3:0] REG_ENV_COARSE = 4'd12;
	localparam logic [3:0] REG_SHAPE = 4'd13;

	localparam logic [0:0] CFG_CLK_RATE = 1'b0;
	localparam logic [0:0] CFG_FRAME_LEN = 1'b1;

	function automatic logic [3:0] shape_level(input logic [3:0] shape, input logic [4:0] pos);
		logic [3:0] dn;
		logic [3:0] up;
		logic attack;
		dn = ~pos[3:0];
		up = pos[3:0];
		attack = shape[2];
		if (!pos[4] || !shape[3]) begin
			if (pos[4]) shape_level = 4'd0;
			else shape_level = attack ? up : dn;
		end else begin
			case (shape[2:0])
				3'd0: shape_level = dn;
				3'd1: shape_level = 4'd0;
				3'd2: shape_level = up;
				3'd3: shape_level = 4'd15;
				3'd4: shape_level = up;
				3'd5: shape_level = 4'd15;
				3'd6: shape_level = dn;
				default: shape_level = 4'd0;
			endcase
		end
	endfunction
endpackage
`default_nettype wire

/* rtl/three_voice_sound_generator.sv */
`default_nettype none
// Three-voice square-wave sound generator with noise and envelope, driven by
// register write, register read, frame and sample words. Every input word
// gives exactly one result word. A register read or write goes from idle
// straight to the output state, and no new word is taken until its result
// is posted. A frame word runs five divide steps for the tone, noise and
// envelope steps (the division is skipped where a period is zero), then
// scales the envelope step by the frame length and updates the envelope
// and the volumes. A sample word runs three voice steps, each with a
// 32-step division for edge softening (skipped where the voice does not
// cross its edge), then adds the noise and posts the output. The next
// word can be taken in the cycle after the result is posted. All of the
// divisions use the one shared restoring divider. The result register
// holds while the next word enters. A result that has not been taken
// stalls the generator only once the next result is ready.
module three_voice_sound_generator
	import tvsg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // opcode[1:0], reg_index[5:2], write_value[13:6]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // read_data[7:0], sample[16:8]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_DIV   = 8'b00000010,
		ST_WAIT  = 8'b00000100,
		ST_MUL   = 8'b00001000,
		ST_ENV   = 8'b00010000,
		ST_VOL   = 8'b00100000,
		ST_MIX   = 8'b01000000,
		ST_OUT   = 8'b10000000
	} state_t;

	state_t state_q;
	logic [15:0] clk_rate_q;
	logic [9:0] frame_len_q;
	logic [7:0] regs_q [RegCount];
	logic [15:0] tone_phase_q [3];
	logic [17:0] tone_step_q [3];
	logic [16:0] noise_phase_q;
	logic [17:0] noise_step_q;
	logic [31:0] noise_shift_q;
	logic noise_bit_q;
	logic [31:0] env_phase_q;
	logic [31:0] env_step_q;
	logic [3:0] env_level_q;
	logic [3:0] voice_vol_q [3];
	logic [5:0] noise_vol_q;
	logic [1:0] op_q;
	logic [2:0] idx_q;
	logic signed [12:0] sum_q;
	logic [7:0] rd_q;
	logic [16:0] num_q;
	logic neg_q;
	logic skip_q;

	logic div_start, div_busy;
	logic [31:0] div_a, div_b, div_q;

	tvsg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .busy(div_busy), .quotient(div_q)
	);

	logic [1:0] in_op;
	logic [3:0] in_idx;
	logic [7:0] in_val;
	assign in_op = s_tdata[1:0];
	assign in_idx = s_tdata[5:2];
	assign in_val = s_tdata[13:6];

	logic [7:0] wr_val;
	always_comb begin
		wr_val = in_val;
		if (in_idx >= REG_VOL_A && in_idx <= REG_VOL_C) wr_val = {3'd0, in_val[4:0]};
		if (in_idx == REG_SHAPE) wr_val = {4'd0, in_val[3:0]};
	end

	assign pready = 1'b1;
	always_comb begin
		case (paddr[2])
			CFG_CLK_RATE: prdata = {16'd0, clk_rate_q};
			default: prdata = {22'd0, frame_len_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_rate_q <= 16'd1;
			frame_len_q <= 10'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == CFG_CLK_RATE) clk_rate_q <= pwdata[15:0];
			else frame_len_q <= pwdata[9:0];
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	logic [11:0] period;
	logic [15:0] tstep;
	logic [15:0] c0, c1;
	logic crossing;
	logic [4:0] vol_sel [3];
	logic [3:0] vol_eff [3];
	logic [31:0] env_sum;
	logic signed [12:0] sum_div;
	logic signed [12:0] sum_sat;
	logic [31:0] nshift;

	always_comb begin
		case (idx_q)
			3'd3: period = {7'd0, regs_q[6][4:0]};
			3'd4: period = 12'hFFF;
			default: period = {regs_q[{1'b0, idx_q[1:0], 1'b1}][3:0],
				regs_q[{1'b0, idx_q[1:0], 1'b0}]};
		endcase
		tstep = tone_step_q[idx_q[1:0]][15:0];
		c0 = tone_phase_q[idx_q[1:0]];
		c1 = c0 + tstep;
		crossing = c0[15] ^ c1[15];
		env_sum = env_phase_q + env_step_q;
		for (int v = 0; v < 3; v++) begin
			vol_sel[v] = regs_q[8 + v][4:0];
			vol_eff[v] = vol_sel[v][4] ? env_level_q : vol_sel[v][3:0];
		end
		sum_div = sum_q / 13'sd8;
		if (sum_div > 13'sd160) sum_sat = 13'sd160;
		else if (sum_div < -13'sd160) sum_sat = -13'sd160;
		else sum_sat = sum_div;
		nshift = {noise_shift_q[30:0], 1'b0};
		if (nshift[31]) nshift = nshift ^ 32'h00040001;
	end

	// env period is 16 bits, handled by its own divide request
	logic [15:0] env_per;
	assign env_per = {regs_q[REG_ENV_COARSE], regs_q[REG_ENV_FINE]};

	logic [16:0] num_mag;
	assign num_mag = num_q[16] ? (17'd0 - num_q) : num_q;

	always_comb begin
		div_start = 1'b0;
		div_a = {14'd0, clk_rate_q, 2'd0};
		div_b = '0;
		if (state_q == ST_DIV) begin
			if (op_q == OP_FRAME) begin
				div_b = (idx_q == 3'd4) ? {16'd0, env_per} : {20'd0, period};
				div_start = (div_b != 32'd0);
			end else begin
				div_a = {11'd0, num_mag, 4'd0};
				div_b = {14'd0, tone_step_q[idx_q[1:0]]};
				div_start = !skip_q;
			end
		end
	end

	logic signed [13:0] lev;
	always_comb begin
		if (skip_q) lev = neg_q ? -14'sd16 : 14'sd16;
		else if (neg_q ^ num_q[16]) lev = -$signed({1'b0, div_q[12:0]});
		else lev = $signed({1'b0, div_q[12:0]});
	end

	logic [31:0] envm;
	assign envm = {14'd0, env_step_q[17:0]} * {22'd0, frame_len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
			for (int i = 0; i < RegCount; i++)
				regs_q[i] <= (i == int'(REG_ENABLE)) ? 8'o77 : 8'd0;
			for (int v = 0; v < 3; v++) begin
				tone_phase_q[v] <= '0;
				tone_step_q[v] <= '0;
				voice_vol_q[v] <= '0;
			end
			noise_phase_q <= '0;
			noise_step_q <= '0;
			noise_shift_q <= 32'd1;
			noise_bit_q <= 1'b0;
			env_phase_q <= '0;
			env_step_q <= '0;
			env_level_q <= 4'd15;
			noise_vol_q <= '0;
			op_q <= OP_WRITE;
			idx_q <= '0;
			sum_q <= '0;
			rd_q <= '0;
			num_q <= '0;
			neg_q <= 1'b0;
			skip_q <= 1'b0;
			m_tdata <= '0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_OUT) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q <= in_op;
						idx_q <= '0;
						sum_q <= '0;
						rd_q <= (in_op == OP_READ) ? regs_q[in_idx] : 8'd0;
						case (in_op)
							OP_WRITE: begin
								regs_q[in_idx] <= wr_val;
								if (in_idx == REG_ENV_FINE || in_idx == REG_ENV_COARSE)
									env_phase_q <= '0;
								state_q <= ST_OUT;
							end
							OP_READ: state_q <= ST_OUT;
							OP_FRAME: state_q <= ST_DIV;
							default: state_q <= ST_MIX;
						endcase
					end
				end
				ST_MIX: begin
					// per-voice sample prep, idx 0..2
					skip_q <= !crossing;
					neg_q <= c0[15];
					num_q <= 17'h8000 - {2'd0, c0[14:0]} - {2'd0, c1[14:0]};
					tone_phase_q[idx_q[1:0]] <= c1;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!div_busy) begin
						if (op_q == OP_FRAME) begin
							case (idx_q)
								3'd3: noise_step_q <= (period == 12'd0) ? 18'd0 : div_q[17:0];
								3'd4: begin
									env_step_q <= (env_per == 16'd0) ? 32'd0 : div_q;
								end
								default: tone_step_q[idx_q[1:0]] <=
									(period == 12'd0) ? 18'd0 : div_q[17:0];
							endcase
							if (idx_q == 3'd4) state_q <= ST_MUL;
							else begin
								idx_q <= idx_q + 3'd1;
								state_q <= ST_DIV;
							end
						end else begin
							sum_q <= sum_q + 13'(lev * $signed({10'd0, voice_vol_q[idx_q[1:0]]}));
							if (idx_q == 3'd2) state_q <= ST_ENV;
							else begin
								idx_q <= idx_q + 3'd1;
								state_q <= ST_MIX;
							end
						end
					end
				end
				ST_MUL: begin
					env_step_q <= envm;
					state_q <= ST_ENV;
				end
				ST_ENV: begin
					if (op_q == OP_FRAME) begin
						env_level_q <= shape_level(regs_q[REG_SHAPE][3:0], env_phase_q[20:16]);
						if (env_sum[31:21] != 11'd0) begin
							if (regs_q[REG_SHAPE][3] && !regs_q[REG_SHAPE][0])
								env_phase_q <= env_sum - 32'h200000;
							else begin
								env_phase_q <= 32'h100000;
								env_step_q <= '0;
							end
						end else begin
							env_phase_q <= env_sum;
						end
						state_q <= ST_VOL;
					end else begin
						noise_phase_q <= {1'b0, noise_phase_q[15:0]} + noise_step_q[16:0];
						if (({3'b0, noise_phase_q[15:0]} + {1'b0, noise_step_q}) >= 19'h10000) begin
							noise_shift_q <= nshift;
							noise_bit_q <= nshift[0];
							sum_q <= sum_q + (nshift[0] ? 13'sd12 : -13'sd12)
								* $signed({7'd0, noise_vol_q});
						end else begin
							sum_q <= sum_q + (noise_bit_q ? 13'sd12 : -13'sd12)
								* $signed({7'd0, noise_vol_q});
						end
						state_q <= ST_OUT;
					end
				end
				ST_VOL: begin
					for (int v = 0; v < 3; v++)
						voice_vol_q[v] <= (regs_q[REG_ENABLE][v] || tone_step_q[v] == 18'd0)
							? 4'd0 : vol_eff[v];
					noise_vol_q <= (noise_step_q == 18'd0) ? 6'd0 :
						(regs_q[REG_ENABLE][3] ? 6'd0 : {2'd0, vol_eff[0]})
						+ (regs_q[REG_ENABLE][4] ? 6'd0 : {2'd0, vol_eff[1]})
						+ (regs_q[REG_ENABLE][5] ? 6'd0 : {2'd0, vol_eff[2]});
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata <= {7'd0, (op_q == OP_SAMPLE) ? sum_sat[8:0] : 9'd0, rd_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/tvsg_div.sv */
`default_nettype none
module tvsg_div
	import tvsg_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [DivW-1:0] dividend,
	input  wire logic [DivW-1:0] divisor,
	output logic                 busy,
	output logic [DivW-1:0]      quotient
);
	logic [DivW-1:0] rem_q;
	logic [DivW-1:0] den_q;
	logic [5:0] cnt_q;
	logic [DivW:0] trial;

	assign trial = {rem_q, quotient[DivW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'(DivW);
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quotient <= dividend;
		end else if (cnt_q != 6'd0) begin
			if (!trial[DivW]) begin
				rem_q <= trial[DivW-1:0];
				quotient <= {quotient[DivW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DivW-2:0], quotient[DivW-1]};
				quotient <= {quotient[DivW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 6'd0);
endmodule
`default_nettype wire
